[sv/tdcsc_pkg.sv]
// ----------------------------------------------------------------------------
// tdcsc_pkg
// Shared types and constants of the thermostat duty-cycle switch controller.
// ----------------------------------------------------------------------------
`default_nettype none

package tdcsc_pkg;

    // Field widths
    localparam int MODE_W    = 2;
    localparam int TARGET_W  = 5;
    localparam int MINUTES_W = 10;
    localparam int TEMP_W    = 12;
    localparam int CNT_W     = 6;
    localparam int SEC_W     = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 10;

    // Temperature window closes after WINDOW_LIMIT+1 ticks
    localparam logic [CNT_W-1:0]     WINDOW_LIMIT   = 6'd60;
    localparam logic [CNT_W-1:0]     VOTE_THRESHOLD = 6'd45;
    localparam logic [CNT_W-1:0]     CNT_MAX        = 6'd63;
    localparam logic [SEC_W-1:0]     SEC_MAX        = 16'hFFFF;
    localparam logic [SEC_W-1:0]     SEC_PER_MIN    = 16'd60;
    // Target is whole degrees, samples are tenths; hysteresis is half a degree
    localparam logic [3:0]           TEMP_SCALE     = 4'd10;
    localparam logic [3:0]           HYST_TENTHS    = 4'd5;

    // Register reset values
    localparam logic [MODE_W-1:0]    RST_RUN_MODE   = 2'd0;
    localparam logic [TARGET_W-1:0]  RST_TARGET     = 5'd26;
    localparam logic [MINUTES_W-1:0] RST_MINUTES    = 10'd30;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_RUN_MODE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_TEMP = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ON_MINUTES  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OFF_MINUTES = 2'd3;

    // Operating modes
    typedef enum logic [MODE_W-1:0] {
        MODE_ONOFF = 2'd0,
        MODE_TIMED = 2'd1,
        MODE_TEMP  = 2'd2
    } t_mode;

    typedef struct packed {
        logic [MODE_W-1:0]    run_mode;
        logic [TARGET_W-1:0]  target_temp;
        logic [MINUTES_W-1:0] on_minutes;
        logic [MINUTES_W-1:0] off_minutes;
    } t_cfg;

    typedef struct packed {
        logic              cmd;
        logic              remote_enabled;
        logic              manual_on;
        logic [TEMP_W-1:0] temp_tenths;
    } t_item;

    typedef struct packed {
        logic             system_on;
        logic             move_now;
        logic [CNT_W-1:0] last_votes;
        logic [SEC_W-1:0] elapsed_seconds;
    } t_result;

endpackage

`default_nettype wire

[sv/thermostat_duty_cycle_switch_control.sv]
// ----------------------------------------------------------------------------
// thermostat_duty_cycle_switch_control
// On/off air-conditioner switch controller: manual, timed and temperature
// regulated operation, one result beat per input beat.
// ----------------------------------------------------------------------------
//  Channel   Handshake                  Payload
//  in        i_in_valid / o_in_stall    cmd, remote_enabled, manual_on, temp_tenths
//  out       o_out_valid / i_out_stall  system_on, move_now, last_votes, elapsed_seconds
//  cfg       i_cfg_we                   i_cfg_index, i_cfg_data
//
//  Each beat passes the input register, then the result register. One beat per
//  cycle unless the output stalls; the controller state updates as a beat moves
//  from the input register into the result register, so the next beat sees it at once.
//  Reset is synchronous, active low; it clears both valid flags and the state.
//  A stall on the output holds the result register, then the input register.
// ----------------------------------------------------------------------------
`default_nettype none

module thermostat_duty_cycle_switch_control (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    // configuration
    input  wire                                i_cfg_we,
    input  wire  [tdcsc_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire  [tdcsc_pkg::CFG_DAT_W-1:0]    i_cfg_data,
    // input channel
    input  wire                                i_in_valid,
    output logic                               o_in_stall,
    input  wire                                i_cmd,
    input  wire                                i_remote_enabled,
    input  wire                                i_manual_on,
    input  wire  [tdcsc_pkg::TEMP_W-1:0]       i_temp_tenths,
    // output channel
    output logic                               o_out_valid,
    input  wire                                i_out_stall,
    output logic                               o_system_on,
    output logic                               o_move_now,
    output logic [tdcsc_pkg::CNT_W-1:0]        o_last_votes,
    output logic [tdcsc_pkg::SEC_W-1:0]        o_elapsed_seconds
);

    tdcsc_pkg::t_cfg    w_cfg;
    tdcsc_pkg::t_item   r_item;
    tdcsc_pkg::t_result w_res;
    tdcsc_pkg::t_result r_res;
    logic               r_in_valid;
    logic               r_out_valid;
    logic               w_adv;
    logic               w_fire;

    tdcsc_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    // Pipeline control
    assign w_adv      = !r_out_valid || !i_out_stall;
    assign w_fire     = r_in_valid && w_adv;
    assign o_in_stall = r_in_valid && !w_adv;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_item.cmd            <= i_cmd;
            r_item.remote_enabled <= i_remote_enabled;
            r_item.manual_on      <= i_manual_on;
            r_item.temp_tenths    <= i_temp_tenths;
        end
    end

    tdcsc_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (w_fire),
        .i_item  (r_item),
        .i_cfg   (w_cfg),
        .o_res   (w_res)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_res <= w_res;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_system_on       = r_res.system_on;
    assign o_move_now        = r_res.move_now;
    assign o_last_votes      = r_res.last_votes;
    assign o_elapsed_seconds = r_res.elapsed_seconds;

endmodule

`default_nettype wire

[sv/tdcsc_cfg.sv]
// ----------------------------------------------------------------------------
// tdcsc_cfg
// Configuration register file: run mode, target temperature, on/off minutes.
// ----------------------------------------------------------------------------
`default_nettype none

module tdcsc_cfg (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_cfg_we,
    input  wire  [tdcsc_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire  [tdcsc_pkg::CFG_DAT_W-1:0]    i_cfg_data,
    output tdcsc_pkg::t_cfg                    o_cfg
);

    tdcsc_pkg::t_cfg r_cfg;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.run_mode    <= tdcsc_pkg::RST_RUN_MODE;
            r_cfg.target_temp <= tdcsc_pkg::RST_TARGET;
            r_cfg.on_minutes  <= tdcsc_pkg::RST_MINUTES;
            r_cfg.off_minutes <= tdcsc_pkg::RST_MINUTES;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                tdcsc_pkg::REG_RUN_MODE: begin
                    r_cfg.run_mode <= i_cfg_data[tdcsc_pkg::MODE_W-1:0];
                end
                tdcsc_pkg::REG_TARGET_TEMP: begin
                    r_cfg.target_temp <= i_cfg_data[tdcsc_pkg::TARGET_W-1:0];
                end
                tdcsc_pkg::REG_ON_MINUTES: begin
                    r_cfg.on_minutes <= i_cfg_data[tdcsc_pkg::MINUTES_W-1:0];
                end
                tdcsc_pkg::REG_OFF_MINUTES: begin
                    r_cfg.off_minutes <= i_cfg_data[tdcsc_pkg::MINUTES_W-1:0];
                end
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

[sv/tdcsc_core.sv]
// ----------------------------------------------------------------------------
// tdcsc_core
// Controller state and single-pass next-state logic for one beat.
// ----------------------------------------------------------------------------
`default_nettype none

module tdcsc_core (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_fire,
    input  wire tdcsc_pkg::t_item  i_item,
    input  wire tdcsc_pkg::t_cfg   i_cfg,
    output tdcsc_pkg::t_result     o_res
);

    // State
    logic                         r_switch_on;
    logic [tdcsc_pkg::SEC_W-1:0]  r_sec;
    logic [tdcsc_pkg::CNT_W-1:0]  r_win;
    logic [tdcsc_pkg::CNT_W-1:0]  r_ach;
    logic [tdcsc_pkg::CNT_W-1:0]  r_prev;
    tdcsc_pkg::t_mode             r_mode;

    logic                         n_switch_on;
    logic [tdcsc_pkg::SEC_W-1:0]  n_sec;
    logic [tdcsc_pkg::CNT_W-1:0]  n_win;
    logic [tdcsc_pkg::CNT_W-1:0]  n_ach;
    logic [tdcsc_pkg::CNT_W-1:0]  n_prev;

    logic                         w_tick;
    logic                         w_remote;
    tdcsc_pkg::t_mode             w_mode;
    logic [tdcsc_pkg::SEC_W-1:0]  w_sec_inc;
    logic                         w_sw_a;
    logic                         w_move_a;
    logic                         w_move_b;
    logic [tdcsc_pkg::SEC_W-1:0]  w_sec_b;
    logic [tdcsc_pkg::SEC_W-1:0]  w_limit;
    logic                         w_time_up;
    logic [8:0]                   w_target;
    logic [12:0]                  w_temp_x;
    logic [12:0]                  w_target_x;
    logic                         w_met;
    logic                         w_temp_act;
    logic [tdcsc_pkg::CNT_W-1:0]  w_ach_inc;
    logic                         w_win_end;
    logic                         w_flip;
    logic                         w_move;

    assign w_tick   = !i_item.cmd;
    assign w_remote = i_item.remote_enabled;

    // Mode in effect; local operation and the unused code run as on/off
    always_comb begin
        if (!w_remote) begin
            w_mode = tdcsc_pkg::MODE_ONOFF;
        end else begin
            unique case (i_cfg.run_mode)
                tdcsc_pkg::MODE_TIMED: w_mode = tdcsc_pkg::MODE_TIMED;
                tdcsc_pkg::MODE_TEMP:  w_mode = tdcsc_pkg::MODE_TEMP;
                default:               w_mode = tdcsc_pkg::MODE_ONOFF;
            endcase
        end
    end

    // Elapsed time advances on ticks, saturating
    assign w_sec_inc = (w_tick && (r_sec != tdcsc_pkg::SEC_MAX)) ? r_sec + 16'd1 : r_sec;

    // Manual follow or remote toggle
    assign w_sw_a   = !w_remote ? i_item.manual_on
                    : (!w_tick ? !r_switch_on : r_switch_on);
    assign w_move_a = !w_remote ? (i_item.manual_on != r_switch_on) : !w_tick;
    assign w_move_b = w_move_a || (w_mode != r_mode);
    assign w_sec_b  = w_move_b ? '0 : w_sec_inc;

    // Timed mode: minutes * 60 fits 16 bits
    assign w_limit   = tdcsc_pkg::SEC_W'(w_sw_a ? i_cfg.on_minutes : i_cfg.off_minutes)
                     * tdcsc_pkg::SEC_PER_MIN;
    assign w_time_up = w_tick && (w_mode == tdcsc_pkg::MODE_TIMED) && (w_sec_b >= w_limit);

    // Temperature mode: hysteresis compare in tenths
    assign w_target   = 9'(i_cfg.target_temp) * 9'(tdcsc_pkg::TEMP_SCALE);
    assign w_temp_x   = 13'(i_item.temp_tenths);
    assign w_target_x = 13'(w_target);
    assign w_met      = w_sw_a ? ((w_temp_x + 13'(tdcsc_pkg::HYST_TENTHS)) < w_target_x)
                               : (w_temp_x > (w_target_x + 13'(tdcsc_pkg::HYST_TENTHS)));
    assign w_temp_act = w_tick && (w_mode == tdcsc_pkg::MODE_TEMP);
    assign w_ach_inc  = (w_met && (r_ach != tdcsc_pkg::CNT_MAX)) ? r_ach + 6'd1 : r_ach;
    assign w_win_end  = w_temp_act && (r_win >= tdcsc_pkg::WINDOW_LIMIT);

    assign w_flip = w_time_up || (w_win_end && (w_ach_inc >= tdcsc_pkg::VOTE_THRESHOLD));
    assign w_move = w_move_b || w_time_up || w_win_end;

    // Next state
    always_comb begin
        n_switch_on = w_sw_a ^ w_flip;
        n_sec       = (w_time_up || w_win_end) ? '0 : w_sec_b;
        n_win       = r_win;
        n_ach       = r_ach;
        n_prev      = r_prev;
        if (w_temp_act) begin
            if (w_win_end) begin
                n_win  = '0;
                n_ach  = '0;
                n_prev = w_ach_inc;
            end else begin
                n_win  = r_win + 6'd1;
                n_ach  = w_ach_inc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_switch_on <= 1'b0;
            r_sec       <= '0;
            r_win       <= '0;
            r_ach       <= '0;
            r_prev      <= '0;
            r_mode      <= tdcsc_pkg::MODE_ONOFF;
        end else if (i_fire) begin
            r_switch_on <= n_switch_on;
            r_sec       <= n_sec;
            r_win       <= n_win;
            r_ach       <= n_ach;
            r_prev      <= n_prev;
            r_mode      <= w_mode;
        end
    end

    // Result of this beat
    assign o_res.system_on       = n_switch_on;
    assign o_res.move_now        = w_move;
    assign o_res.last_votes      = n_prev;
    assign o_res.elapsed_seconds = n_sec;

endmodule

`default_nettype wire

[sv/tdcsc_checker.sv]
// ----------------------------------------------------------------------------
// tdcsc_checker
// Port-level checks of the switch controller, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module tdcsc_checker (
    input wire                              i_clk,
    input wire                              i_rst_n,
    input wire                              o_in_stall,
    input wire                              o_out_valid,
    input wire                              i_out_stall,
    input wire                              o_system_on,
    input wire                              o_move_now,
    input wire [tdcsc_pkg::CNT_W-1:0]       o_last_votes,
    input wire [tdcsc_pkg::SEC_W-1:0]       o_elapsed_seconds
);

    // A stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_system_on)
            && $stable(o_move_now) && $stable(o_last_votes)
            && $stable(o_elapsed_seconds))
        else $error("result beat changed while stalled");

    // A move always restarts the elapsed time
    a_move_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_move_now |-> o_elapsed_seconds == '0)
        else $error("move beat with nonzero elapsed seconds");

    // A window holds at most WINDOW_LIMIT+1 ticks
    a_votes_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_last_votes <= tdcsc_pkg::WINDOW_LIMIT + 6'd1)
        else $error("window vote count out of range");

    // With the result register empty the input side never stalls
    a_no_idle_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> !o_in_stall)
        else $error("input stalled with empty result register");

endmodule

bind thermostat_duty_cycle_switch_control tdcsc_checker u_tdcsc_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .o_in_stall        (o_in_stall),
    .o_out_valid       (o_out_valid),
    .i_out_stall       (i_out_stall),
    .o_system_on       (o_system_on),
    .o_move_now        (o_move_now),
    .o_last_votes      (o_last_votes),
    .o_elapsed_seconds (o_elapsed_seconds)
);

`default_nettype wire
